FILE: hdl/mm4_pkg.sv
`timescale 1ns / 1ps

package mm4_pkg;

  localparam int ORDER = 4;
  localparam int QBITS = 16;
  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  // Four products summed need two guard bits.
  localparam int SUM_W = PROD_W + 2;
  localparam int SHR_W = SUM_W - QBITS;
  localparam int COL_W = $clog2(ORDER);

  // Request codes.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_MULT = 1'b1;

  typedef logic signed [DATA_W-1:0] q16_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [COL_W-1:0] col_idx_t;

  // One column of rows; a matrix is indexed [column][row].
  typedef q16_t vec_t [ORDER];
  typedef vec_t mat_t [ORDER];

  // Products of one output row, indexed by k.
  typedef prod_t prow_t [ORDER];
  // All products, indexed [row][k].
  typedef prow_t pmat_t [ORDER];

endpackage

FILE: hdl/mm4_in_if.sv
`timescale 1ns / 1ps

interface mm4_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [1:0]  column;
  logic signed [31:0] elem_row0;
  logic signed [31:0] elem_row1;
  logic signed [31:0] elem_row2;
  logic signed [31:0] elem_row3;
  logic        commit_last;

  modport source (
    output valid, req_type, column, elem_row0, elem_row1, elem_row2, elem_row3,
           commit_last,
    input  ready
  );

  modport sink (
    input  valid, req_type, column, elem_row0, elem_row1, elem_row2, elem_row3,
           commit_last,
    output ready
  );
endinterface

FILE: hdl/mm4_out_if.sv
`timescale 1ns / 1ps

interface mm4_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_column;
  logic signed [31:0] out_row0;
  logic signed [31:0] out_row1;
  logic signed [31:0] out_row2;
  logic signed [31:0] out_row3;
  logic        saturated;

  modport source (
    output valid, out_column, out_row0, out_row1, out_row2, out_row3, saturated,
    input  ready
  );

  modport sink (
    input  valid, out_column, out_row0, out_row1, out_row2, out_row3, saturated,
    output ready
  );
endinterface

FILE: hdl/matrix_multiply_4x4_core.sv
`timescale 1ns / 1ps
// An accepted item is held in the input register, then in the result register.
// Throughput: one item per cycle unless the output stalls; a commit writes the current
//   matrix on the same edge the next item enters, so that item multiplies against it.
// Products come from 16 parallel 32x32 multipliers feeding four 66-bit row adders.
// Reset: asynchronous active low; clears all valids and both matrix stores to zero.

module matrix_multiply_4x4_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  mm4_in_if.sink    in_i,
  mm4_out_if.source out_o
);
  import mm4_pkg::*;

  // ---------------------------------------------------------------------
  // Pipeline registers
  // ---------------------------------------------------------------------
  // Input stage
  logic     s1_v_q, s1_v_d;
  logic     s1_req_q;
  col_idx_t s1_col_q;
  logic     s1_commit_q;
  vec_t     s1_elem_q;

  // Result stage
  logic     out_v_q, out_v_d;
  col_idx_t out_col_q;
  vec_t     out_row_q;
  logic     out_sat_q;

  // Matrix stores
  mat_t     cur_q;
  mat_t     pend_q;

  // ---------------------------------------------------------------------
  // Flow control
  // ---------------------------------------------------------------------
  logic in_acc_w;
  logic out_en_w, s1_mv_w, s1_en_w;

  // Advance the input stage whenever the result register is free or drains.
  assign out_en_w = ~out_v_q | out_o.ready;
  assign s1_mv_w  = s1_v_q & out_en_w;
  assign s1_en_w  = ~s1_v_q | s1_mv_w;

  assign in_i.ready = s1_en_w;
  assign in_acc_w   = in_i.valid & in_i.ready;

  always_comb begin
    s1_v_d  = s1_en_w  ? in_acc_w : s1_v_q;
    out_v_d = out_en_w ? s1_mv_w  : out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  // ---------------------------------------------------------------------
  // Input stage: capture the item
  // ---------------------------------------------------------------------
  vec_t in_elem_w;

  assign in_elem_w = '{in_i.elem_row0, in_i.elem_row1, in_i.elem_row2, in_i.elem_row3};

  always_ff @(posedge clk_i) begin
    if (in_acc_w) begin
      s1_req_q    <= in_i.req_type;
      s1_col_q    <= in_i.column;
      s1_commit_q <= in_i.commit_last;
      s1_elem_q   <= in_elem_w;
    end
  end

  // ---------------------------------------------------------------------
  // Products against the current matrix, then reduce, shift, saturate
  // ---------------------------------------------------------------------
  pmat_t            prod_w;
  vec_t             dot_w;
  logic [ORDER-1:0] clip_w;
  vec_t             res_w;
  logic             sat_w;

  mm4_prod_array u_prod (
    .cur_i  (cur_q),
    .opc_i  (s1_elem_q),
    .prod_o (prod_w)
  );

  for (genvar r = 0; r < ORDER; r++) begin : g_row
    mm4_row_reduce u_reduce (
      .prod_i (prod_w[r]),
      .res_o  (dot_w[r]),
      .clip_o (clip_w[r])
    );
  end

  // Load items echo their elements and never clip.
  always_comb begin
    if (s1_req_q == REQ_MULT) begin
      res_w = dot_w;
      sat_w = |clip_w;
    end else begin
      res_w = s1_elem_q;
      sat_w = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_mv_w) begin
      out_col_q <= s1_col_q;
      out_row_q <= res_w;
      out_sat_q <= sat_w;
    end
  end

  // ---------------------------------------------------------------------
  // Matrix stores
  // ---------------------------------------------------------------------
  // Every item updates the stores as it leaves the input stage, so the next
  // item always multiplies against the matrix its predecessors left. Loads
  // write the current matrix; multiplies write the pending store; a commit
  // copies pending (with this column) into current and clears pending.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < ORDER; c++) begin
        for (int r = 0; r < ORDER; r++) begin
          cur_q[c][r]  <= '0;
          pend_q[c][r] <= '0;
        end
      end
    end else begin
      if (s1_mv_w) begin
        if (s1_req_q == REQ_LOAD) begin
          cur_q[s1_col_q] <= s1_elem_q;
        end else if (s1_commit_q) begin
          for (int c = 0; c < ORDER; c++) begin
            if (col_idx_t'(c) == s1_col_q) begin
              cur_q[c] <= res_w;
            end else begin
              cur_q[c] <= pend_q[c];
            end
            for (int r = 0; r < ORDER; r++) begin
              pend_q[c][r] <= '0;
            end
          end
        end else begin
          pend_q[s1_col_q] <= res_w;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output port
  // ---------------------------------------------------------------------
  assign out_o.valid      = out_v_q;
  assign out_o.out_column = out_col_q;
  assign out_o.out_row0   = out_row_q[0];
  assign out_o.out_row1   = out_row_q[1];
  assign out_o.out_row2   = out_row_q[2];
  assign out_o.out_row3   = out_row_q[3];
  assign out_o.saturated  = out_sat_q;

endmodule

FILE: hdl/mm4_prod_array.sv
`timescale 1ns / 1ps

module mm4_prod_array (
  input  mm4_pkg::mat_t  cur_i,
  input  mm4_pkg::vec_t  opc_i,
  output mm4_pkg::pmat_t prod_o
);
  import mm4_pkg::*;

  // One 32x32 signed multiplier per matrix element.
  always_comb begin
    for (int r = 0; r < ORDER; r++) begin
      for (int k = 0; k < ORDER; k++) begin
        prod_o[r][k] = prod_t'(cur_i[k][r]) * prod_t'(opc_i[k]);
      end
    end
  end

endmodule

FILE: hdl/mm4_row_reduce.sv
`timescale 1ns / 1ps

module mm4_row_reduce (
  input  mm4_pkg::prow_t prod_i,
  output mm4_pkg::q16_t  res_o,
  output logic           clip_o
);
  import mm4_pkg::*;

  logic signed [SUM_W-1:0] sum_w;
  logic signed [SHR_W-1:0] shr_w;
  logic                    fits_w;

  always_comb begin
    sum_w = '0;
    for (int k = 0; k < ORDER; k++) begin
      sum_w = sum_w + SUM_W'(prod_i[k]);
    end
  end

  // Floor shift: drop the fraction bits of the exact sum.
  assign shr_w  = sum_w[SUM_W-1:QBITS];
  assign fits_w = (&shr_w[SHR_W-1:DATA_W-1]) | ~(|shr_w[SHR_W-1:DATA_W-1]);
  assign clip_o = ~fits_w;

  always_comb begin
    if (fits_w) begin
      res_o = shr_w[DATA_W-1:0];
    end else if (shr_w[SHR_W-1]) begin
      res_o = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule

FILE: dv/mm4_column_checker.sv
`timescale 1ns / 1ps

module mm4_column_checker (
  input  logic clk_i,
  input  logic rst_ni,
  mm4_in_if    in_ch_i,
  mm4_out_if   out_ch_i,
  output int   mismatches_o,
  output int   outstanding_o
);
  import mm4_pkg::*;

  typedef logic [ORDER-1:0][DATA_W-1:0] col_bits_t;

  typedef struct packed {
    col_idx_t  column;
    col_bits_t rows;
    logic      saturated;
  } col_result_t;

  localparam q16_t Q16_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam q16_t Q16_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Shadow stores, indexed [column][row].
  q16_t        cur_mat  [ORDER][ORDER];
  q16_t        pend_mat [ORDER][ORDER];
  col_result_t expected_cols [$];
  int          errors;

  // Row r of the current matrix times the operand column: floor shift, then clip.
  function automatic q16_t product_row(input int r, input col_bits_t opnd, inout logic clip);
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] lhs;
    logic signed [SUM_W-1:0] rhs;
    logic signed [SUM_W-1:0] shifted;
    acc = '0;
    for (int k = 0; k < ORDER; k++) begin
      lhs = SUM_W'(cur_mat[k][r]);
      rhs = SUM_W'(q16_t'(opnd[k]));
      acc += lhs * rhs;
    end
    shifted = acc >>> QBITS;
    if (shifted[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){shifted[SUM_W-1]}}) begin
      clip = 1'b1;
      return shifted[SUM_W-1] ? Q16_MIN : Q16_MAX;
    end
    return shifted[DATA_W-1:0];
  endfunction

  // Update the shadow stores for one item and return the column it produces.
  function automatic col_result_t apply_item(input logic req, input col_idx_t col,
                                             input col_bits_t elems, input logic last);
    col_result_t res;
    logic        clip;
    clip       = 1'b0;
    res.column = col;
    if (req == REQ_LOAD) begin
      res.rows = elems;
      for (int r = 0; r < ORDER; r++) cur_mat[col][r] = q16_t'(elems[r]);
    end else begin
      for (int r = 0; r < ORDER; r++) res.rows[r] = product_row(r, elems, clip);
      for (int r = 0; r < ORDER; r++) pend_mat[col][r] = q16_t'(res.rows[r]);
      if (last) begin
        cur_mat = pend_mat;
        for (int c = 0; c < ORDER; c++)
          for (int r = 0; r < ORDER; r++) pend_mat[c][r] = '0;
      end
    end
    res.saturated = clip;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] want_v,
                                 input logic [DATA_W-1:0] got_v);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
    errors++;
  endtask

  always @(posedge clk_i) begin : watch
    col_result_t want;
    col_bits_t   got_rows;
    col_bits_t   in_rows;
    if (!rst_ni) begin
      for (int c = 0; c < ORDER; c++)
        for (int r = 0; r < ORDER; r++) begin
          cur_mat[c][r]  = '0;
          pend_mat[c][r] = '0;
        end
      expected_cols.delete();
      errors = 0;
    end else begin
      // Retire first, so an output never matches an item taken at the same edge.
      if (out_ch_i.valid && out_ch_i.ready) begin
        if (expected_cols.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual column %0d",
                   $time, out_ch_i.out_column);
          errors++;
        end else begin
          want     = expected_cols.pop_front();
          got_rows = {out_ch_i.out_row3, out_ch_i.out_row2,
                      out_ch_i.out_row1, out_ch_i.out_row0};
          if (out_ch_i.out_column !== want.column)
            report_mismatch("out_column", DATA_W'(want.column), DATA_W'(out_ch_i.out_column));
          for (int r = 0; r < ORDER; r++)
            if (got_rows[r] !== want.rows[r])
              report_mismatch($sformatf("out_row%0d", r), want.rows[r], got_rows[r]);
          if (out_ch_i.saturated !== want.saturated)
            report_mismatch("saturated", DATA_W'(want.saturated), DATA_W'(out_ch_i.saturated));
        end
      end
      if (in_ch_i.valid && in_ch_i.ready) begin
        in_rows = {in_ch_i.elem_row3, in_ch_i.elem_row2, in_ch_i.elem_row1, in_ch_i.elem_row0};
        expected_cols.push_back(apply_item(in_ch_i.req_type, in_ch_i.column, in_rows,
                                           in_ch_i.commit_last));
      end
    end
    mismatches_o  <= errors;
    outstanding_o <= expected_cols.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the 4x4 Q16.16 matrix multiplier. A short directed
// pass hits the zero matrix, full-scale operands, saturation both ways, floor
// rounding of negatives, repeated columns and partial commits; random
// transform sequences (loads, then a multiply pass closed by a commit) follow,
// mixed with noise items. Checking lives in mm4_column_checker.
module tb;
  import mm4_pkg::*;

  localparam int RANDOM_ITEMS = 1550;
  localparam int CYCLE_LIMIT  = 200000;
  // Two pipeline registers; round up.
  localparam int DRAIN_CYCLES = 10;

  localparam q16_t Q_MAX   = 32'sh7FFF_FFFF;
  localparam q16_t Q_MIN   = 32'sh8000_0000;
  localparam q16_t Q_ONE   = 32'sh0001_0000;
  localparam q16_t Q_M_ONE = -32'sh0001_0000;
  localparam q16_t Q_LSB_N = -32'sh0000_0001;

  // Receiver behavior; each mode holds for a random stretch of cycles.
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  int mismatch_count;
  int cols_outstanding;
  int items_sent;
  int burst_left;
  int cycle_count;

  rx_mode_e rx_mode;
  int       rx_left;
  int       rx_phase;

  mm4_in_if  in_ch ();
  mm4_out_if out_ch ();

  matrix_multiply_4x4_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  mm4_column_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ch_i       (in_ch),
    .out_ch_i      (out_ch),
    .mismatches_o  (mismatch_count),
    .outstanding_o (cols_outstanding)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: pick a stall mode, hold it for a while, then pick again.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      rx_left      = 0;
      rx_phase     = 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        RX_OPEN:     out_ch.ready <= 1'b1;
        RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:   out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:     out_ch.ready <= ((rx_phase % 5) == 0);
      endcase
    end
  end

  // Mostly small values so chained products stay meaningful; some full-range
  // words and corner values to toggle every bit and force clipping.
  function automatic q16_t pick_elem();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 5) return q16_t'($urandom());
    if (sel < 16) return q16_t'(int'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
    case ($urandom_range(0, 6))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return Q_LSB_N;
      4:       return Q_ONE;
      5:       return Q_M_ONE;
      default: return 32'sh0000_0001;
    endcase
  endfunction

  // Present one item and hold it until the block takes it. At the start of
  // each burst, drop valid for a random gap.
  task automatic send_item(input logic req, input col_idx_t col, input q16_t r0,
                           input q16_t r1, input q16_t r2, input q16_t r3,
                           input logic last);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= req;
    in_ch.column      <= col;
    in_ch.elem_row0   <= r0;
    in_ch.elem_row1   <= r1;
    in_ch.elem_row2   <= r2;
    in_ch.elem_row3   <= r3;
    in_ch.commit_last <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  // Stop sending and wait for every expected column. The outstanding count
  // is registered in the checker, so always advance at least once before reading it.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (cols_outstanding != 0);
  endtask

  // Multiply columns mostly in rotating order, sometimes random or repeated;
  // the final one carries the commit mark.
  task automatic send_multiply_pass(input int n_cols);
    col_idx_t col;
    int       start;
    start = $urandom_range(0, ORDER - 1);
    for (int m = 0; m < n_cols; m++) begin
      if ($urandom_range(0, 4) == 0) col = col_idx_t'($urandom_range(0, ORDER - 1));
      else col = col_idx_t'((start + m) % ORDER);
      send_item(REQ_MULT, col, pick_elem(), pick_elem(), pick_elem(), pick_elem(),
                m == n_cols - 1);
    end
  endtask

  // Stop the run if it hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL matrix_multiply_4x4_core");
    $finish;
  end

  initial begin
    int next_pause;
    int kind;
    items_sent         = 0;
    burst_left         = 0;
    // Drive every input to a known value from time zero.
    rst_ni            <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_LOAD;
    in_ch.column      <= '0;
    in_ch.elem_row0   <= '0;
    in_ch.elem_row1   <= '0;
    in_ch.elem_row2   <= '0;
    in_ch.elem_row3   <= '0;
    in_ch.commit_last <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Multiply against the reset matrix: every product is zero.
    send_item(REQ_MULT, col_idx_t'(2), Q_MAX, Q_MIN, Q_LSB_N, '0, 1'b0);
    // Commit with only two columns multiplied; the rest commit as zero.
    send_item(REQ_MULT, col_idx_t'(1), Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b1);
    // Load corner values; the commit mark on a load is ignored.
    send_item(REQ_LOAD, col_idx_t'(0), Q_MAX, Q_MIN, '0, Q_LSB_N, 1'b1);
    send_item(REQ_LOAD, col_idx_t'(1), Q_MIN, Q_MAX, 32'sh0000_0001, Q_ONE, 1'b0);
    send_item(REQ_LOAD, col_idx_t'(2), '0, '0, Q_ONE, '0, 1'b0);
    send_item(REQ_LOAD, col_idx_t'(3), '0, '0, '0, Q_ONE, 1'b0);
    // Full-scale operands: clip high and low.
    send_item(REQ_MULT, col_idx_t'(0), Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0);
    send_item(REQ_MULT, col_idx_t'(1), Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0);
    // Same column again: overwrite the pending column.
    send_item(REQ_MULT, col_idx_t'(1), Q_ONE, '0, '0, '0, 1'b0);
    // Tiny negatives: the shift rounds toward minus infinity.
    send_item(REQ_MULT, col_idx_t'(3), Q_LSB_N, Q_LSB_N, Q_LSB_N, Q_LSB_N, 1'b0);
    send_item(REQ_MULT, col_idx_t'(2), '0, Q_ONE, Q_ONE, '0, 1'b1);
    // Read back the committed matrix, then commit a single column.
    send_item(REQ_MULT, col_idx_t'(0), Q_ONE, '0, '0, '0, 1'b1);
    send_item(REQ_MULT, col_idx_t'(1), Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b0);
    send_item(REQ_MULT, col_idx_t'(3), Q_M_ONE, Q_M_ONE, Q_M_ONE, Q_M_ONE, 1'b1);
    // Identity times odd operands: exact results up to the extremes.
    for (int c = 0; c < ORDER; c++)
      send_item(REQ_LOAD, col_idx_t'(c), (c == 0) ? Q_ONE : '0, (c == 1) ? Q_ONE : '0,
                (c == 2) ? Q_ONE : '0, (c == 3) ? Q_ONE : '0, 1'b0);
    send_item(REQ_MULT, col_idx_t'(0), 32'sh0002_8000, Q_LSB_N, Q_MIN, Q_MAX, 1'b0);
    send_item(REQ_MULT, col_idx_t'(3), 32'sh1234_5678, 32'shEDCB_A988, Q_M_ONE,
              32'sh0000_8000, 1'b1);
    send_item(REQ_MULT, col_idx_t'(2), Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b1);
    // Let the pipe empty completely at least once.
    drain_results();

    items_sent = 0;
    next_pause = $urandom_range(150, 400);
    while (items_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 7) begin
        // Transform sequences: reload the matrix most of the time, then a
        // multiply pass closed by a commit.
        if (kind <= 5) begin
          if ($urandom_range(0, 3) != 0) begin
            for (int c = 0; c < ORDER; c++)
              send_item(REQ_LOAD, col_idx_t'(c), pick_elem(), pick_elem(), pick_elem(),
                        pick_elem(), 1'($urandom_range(0, 1)));
          end else begin
            repeat ($urandom_range(1, 3))
              send_item(REQ_LOAD, col_idx_t'($urandom_range(0, ORDER - 1)), pick_elem(),
                        pick_elem(), pick_elem(), pick_elem(), 1'($urandom_range(0, 1)));
          end
        end
        send_multiply_pass(($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : ORDER);
      end else begin
        // Noise: any request, any column, any commit mark.
        repeat ($urandom_range(1, 4))
          send_item(1'($urandom_range(0, 1)), col_idx_t'($urandom_range(0, ORDER - 1)),
                    pick_elem(), pick_elem(), pick_elem(), pick_elem(),
                    1'($urandom_range(0, 1)));
      end
      if (items_sent >= next_pause) begin
        drain_results();
        next_pause = items_sent + $urandom_range(150, 400);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS matrix_multiply_4x4_core");
    end else begin
      $display("FAIL matrix_multiply_4x4_core");
    end
    $finish;
  end

endmodule

FILE: matrix_multiply_4x4_core.f
hdl/mm4_pkg.sv
hdl/mm4_in_if.sv
hdl/mm4_out_if.sv
hdl/mm4_prod_array.sv
hdl/mm4_row_reduce.sv
hdl/matrix_multiply_4x4_core.sv
dv/mm4_column_checker.sv
dv/tb.sv
